/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
// needs clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// same-cycle implication outside reset
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/fbfl_pkg.sv */
// shared types and constants of the fixed block free list allocator
// no dependencies
`default_nettype none

package fbfl_pkg;

	localparam int unsigned CfgW  = 13;
	localparam int unsigned IdxW  = 12;
	localparam int unsigned OffW  = 24;
	localparam int unsigned SizeW = 14;

	typedef enum logic [1:0] {
		RSP_ALLOC     = 2'd0,
		RSP_FREED     = 2'd1,
		RSP_IGNORED   = 2'd2,
		RSP_EXHAUSTED = 2'd3
	} rsp_code_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic {
		CFG_BLOCK_SIZE  = 1'b0,
		CFG_PAGE_BLOCKS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CARVE,
		S_POP_RD,
		S_POP_FIN
	} state_t;

	typedef struct packed {
		logic      push_free;
		logic      pop_read;
		logic      carve_start;
		logic      carve_step;
		logic      pop_finish;
		logic      rsp_load;
		rsp_code_t rsp_code;
	} cmd_t;

	typedef struct packed {
		logic head_valid;
		logic carve_fits;
		logic carve_last;
		logic free_ok;
		logic rsp_busy;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/fbfl_ctrl.sv */
// allocator controller: request decode and the carve/pop sequence
// depends on fbfl_pkg
`default_nettype none

module fbfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            func,
	input  fbfl_pkg::sts_t  sts,
	output fbfl_pkg::cmd_t  cmd,
	output logic            req_stall
);

	fbfl_pkg::state_t state_q;
	fbfl_pkg::state_t state_d;
	logic             ready;
	logic             accept;

	assign ready     = (state_q == fbfl_pkg::S_IDLE) && !sts.rsp_busy;
	assign accept    = ready && req_valid;
	assign req_stall = !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbfl_pkg::S_IDLE: begin
				if (accept && func == fbfl_pkg::FUNC_ALLOC) begin
					if (sts.head_valid) begin
						state_d = fbfl_pkg::S_POP_FIN;
					end else if (sts.carve_fits) begin
						state_d = fbfl_pkg::S_CARVE;
					end
				end
			end
			fbfl_pkg::S_CARVE: begin
				if (sts.carve_last) begin
					state_d = fbfl_pkg::S_POP_RD;
				end
			end
			fbfl_pkg::S_POP_RD: begin
				state_d = fbfl_pkg::S_POP_FIN;
			end
			fbfl_pkg::S_POP_FIN: begin
				state_d = fbfl_pkg::S_IDLE;
			end
			default: begin
				state_d = fbfl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rsp_code = fbfl_pkg::RSP_ALLOC;
		unique case (state_q)
			fbfl_pkg::S_IDLE: begin
				if (accept) begin
					if (func == fbfl_pkg::FUNC_FREE) begin
						cmd.rsp_load = 1'b1;
						if (sts.free_ok) begin
							cmd.push_free = 1'b1;
							cmd.rsp_code  = fbfl_pkg::RSP_FREED;
						end else begin
							cmd.rsp_code = fbfl_pkg::RSP_IGNORED;
						end
					end else if (sts.head_valid) begin
						cmd.pop_read = 1'b1;
					end else if (sts.carve_fits) begin
						cmd.carve_start = 1'b1;
					end else begin
						cmd.rsp_load = 1'b1;
						cmd.rsp_code = fbfl_pkg::RSP_EXHAUSTED;
					end
				end
			end
			fbfl_pkg::S_CARVE: begin
				cmd.carve_step = 1'b1;
			end
			fbfl_pkg::S_POP_RD: begin
				cmd.pop_read = 1'b1;
			end
			fbfl_pkg::S_POP_FIN: begin
				cmd.pop_finish = 1'b1;
				cmd.rsp_load   = 1'b1;
				cmd.rsp_code   = fbfl_pkg::RSP_ALLOC;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/fbfl_dp.sv */
// allocator datapath: config registers, link memory, list head, page carving,
// offset multiply and the result register; depends on fbfl_pkg
`default_nettype none

module fbfl_dp #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [fbfl_pkg::CfgW-1:0]     cfg_data,
	input  logic [fbfl_pkg::IdxW-1:0]     block_index,
	input  logic                          pointer_present,
	input  logic                          rsp_stall,
	input  fbfl_pkg::cmd_t                cmd,
	output fbfl_pkg::sts_t                sts,
	output logic                          rsp_valid,
	output logic [1:0]                    status,
	output logic [fbfl_pkg::IdxW-1:0]     granted_index,
	output logic [fbfl_pkg::OffW-1:0]     byte_offset,
	output logic [fbfl_pkg::CfgW-1:0]     page_count
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = ((CW > int'(fbfl_pkg::CfgW)) ? CW : int'(fbfl_pkg::CfgW)) + 1;
	localparam int PW = IW + int'(fbfl_pkg::SizeW);
	localparam logic [SW-1:0] MaxBlk = SW'(MAX_BLOCKS);

	logic [fbfl_pkg::CfgW-1:0]  bsize_q;
	logic [fbfl_pkg::CfgW-1:0]  pblocks_q;
	logic [fbfl_pkg::SizeW-1:0] size_min;
	logic [fbfl_pkg::SizeW-1:0] eff_size;

	logic [IW-1:0]              head_q;
	logic                       head_valid_q;
	logic [CW-1:0]              carved_q;
	logic [fbfl_pkg::CfgW-1:0]  pages_q;
	logic [IW-1:0]              carve_addr_q;
	logic [fbfl_pkg::CfgW-1:0]  carve_rem_q;
	logic [IW-1:0]              granted_q;
	logic [IW:0]                rd_q;

	logic [IW:0]                link_mem [MAX_BLOCKS];
	logic                       mem_we;
	logic [IW-1:0]              mem_wa;
	logic [IW:0]                mem_wd;
	logic [IW-1:0]              free_addr;
	logic                       carve_first;
	logic                       carve_last;
	logic [SW-1:0]              carve_end;
	logic [PW-1:0]              prod;

	logic                       rsp_valid_q;
	fbfl_pkg::rsp_code_t        rsp_status_q;
	logic [fbfl_pkg::IdxW-1:0]  rsp_gidx_q;
	logic [fbfl_pkg::OffW-1:0]  rsp_off_q;
	logic [fbfl_pkg::CfgW-1:0]  rsp_pages_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q   <= fbfl_pkg::CfgW'(16);
			pblocks_q <= fbfl_pkg::CfgW'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				fbfl_pkg::CFG_BLOCK_SIZE:  bsize_q   <= cfg_data;
				fbfl_pkg::CFG_PAGE_BLOCKS: pblocks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// minimum 8 bytes, rounded up to 8
	assign size_min = (bsize_q < fbfl_pkg::CfgW'(8)) ? fbfl_pkg::SizeW'(8)
	                                                 : fbfl_pkg::SizeW'(bsize_q);
	assign eff_size = (size_min + fbfl_pkg::SizeW'(7)) & ~fbfl_pkg::SizeW'(7);

	assign free_addr   = IW'(block_index);
	assign carve_first = (carve_addr_q == IW'(carved_q));
	assign carve_last  = (carve_rem_q == fbfl_pkg::CfgW'(1));
	assign carve_end   = SW'(carved_q) + SW'(pblocks_q);

	assign sts.head_valid = head_valid_q;
	assign sts.carve_fits = (pblocks_q != '0) && (carve_end <= MaxBlk);
	assign sts.carve_last = carve_last;
	assign sts.free_ok    = pointer_present && (32'(block_index) < 32'(MAX_BLOCKS));
	assign sts.rsp_busy   = rsp_valid_q && rsp_stall;

	// link memory: valid-link bit on top of the next index
	assign mem_we = cmd.push_free || cmd.carve_step;
	assign mem_wa = cmd.push_free ? free_addr : carve_addr_q;
	assign mem_wd = cmd.push_free ? {head_valid_q, head_q}
	                              : {!carve_first, carve_addr_q - IW'(1)};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (cmd.pop_read) begin
			rd_q <= link_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_read) begin
			granted_q <= head_q;
		end
	end

	// list head, page carving and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			head_valid_q <= 1'b0;
			carved_q     <= '0;
			pages_q      <= '0;
			carve_addr_q <= '0;
			carve_rem_q  <= '0;
		end else begin
			if (cmd.push_free) begin
				head_q       <= free_addr;
				head_valid_q <= 1'b1;
			end else if (cmd.carve_step && carve_last) begin
				head_q       <= carve_addr_q;
				head_valid_q <= 1'b1;
			end else if (cmd.pop_finish) begin
				head_q       <= rd_q[IW-1:0];
				head_valid_q <= rd_q[IW];
			end

			if (cmd.carve_start) begin
				carve_addr_q <= IW'(carved_q);
				carve_rem_q  <= pblocks_q;
			end else if (cmd.carve_step) begin
				carve_addr_q <= carve_addr_q + IW'(1);
				carve_rem_q  <= carve_rem_q - fbfl_pkg::CfgW'(1);
				if (carve_last) begin
					carved_q <= carved_q + CW'(pblocks_q);
					pages_q  <= pages_q + fbfl_pkg::CfgW'(1);
				end
			end
		end
	end

	assign prod = PW'(granted_q) * PW'(eff_size);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_status_q <= cmd.rsp_code;
			rsp_pages_q  <= pages_q;
			if (cmd.pop_finish) begin
				rsp_gidx_q <= fbfl_pkg::IdxW'(granted_q);
				rsp_off_q  <= fbfl_pkg::OffW'(prod);
			end else begin
				rsp_gidx_q <= '0;
				rsp_off_q  <= '0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign granted_index = rsp_gidx_q;
	assign byte_offset   = rsp_off_q;
	assign page_count    = rsp_pages_q;

endmodule

`default_nettype wire

/* rtl/core/fixed_block_free_list_allocator.sv */
// top level of the fixed block free list allocator
// instantiates fbfl_ctrl and fbfl_dp; depends on fbfl_pkg
`default_nettype none

// Hands out fixed-size blocks from a LIFO free list kept in a link memory of
// MAX_BLOCKS entries. A free, a null free and an allocate that finds the pool
// exhausted load the result register on acceptance. A non-empty list
// allocate registers the head link read, then loads the result in S_POP_FIN.
// An empty list allocate first carves a page in S_CARVE, writing one link
// per cycle, then pops in S_POP_RD and S_POP_FIN. A new request is taken
// only when the result register is empty or being emptied in the same cycle.
// No clearing pass runs after reset; configuration writes are always taken.

module fixed_block_free_list_allocator #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        func,
	input  logic [11:0] block_index,
	input  logic        pointer_present,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [11:0] granted_index,
	output logic [23:0] byte_offset,
	output logic [12:0] page_count
);

	fbfl_pkg::cmd_t cmd;
	fbfl_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	fbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (func),
		.sts       (sts),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	fbfl_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.block_index     (block_index),
		.pointer_present (pointer_present),
		.rsp_stall       (rsp_stall),
		.cmd             (cmd),
		.sts             (sts),
		.rsp_valid       (rsp_valid),
		.status          (status),
		.granted_index   (granted_index),
		.byte_offset     (byte_offset),
		.page_count      (page_count)
	);

endmodule

`default_nettype wire

/* rtl/core/fbfl_checker.sv */
// port-level checks of the allocator and their bind to the top level
// depends on fbfl_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module fbfl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  status,
	input logic [11:0] granted_index,
	input logic [23:0] byte_offset
);

	// no new transaction while a result is held back
	`ASSERT_IMPLY(a_no_accept_when_held, rsp_valid && rsp_stall, req_stall)

	// only a grant carries an index or offset
	`ASSERT_IMPLY(a_zero_unless_grant, rsp_valid && (status != fbfl_pkg::RSP_ALLOC), (granted_index == '0) && (byte_offset == '0))

	// held result stays valid
	`ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)

	// held result keeps its payload
	`ASSERT_NEXT(a_rsp_hold_data, rsp_valid && rsp_stall, $stable(status) && $stable(granted_index) && $stable(byte_offset))

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (.*);

`default_nettype wire

/* verif/fixed_block_free_list_allocator_test.sv */
// testbench of the fixed block free list allocator: a directed table, then mixed allocate
// and free traffic under several block and page sizes, each response checked against its
// table row or a behavioral free-list predictor; depends on fbfl_pkg and the allocator RTL

module fixed_block_free_list_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POOL_SIZE = 4096;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int NROWS = 30;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_CFG,
		ROW_DRAIN
	} row_kind_t;

	typedef struct packed {
		fbfl_pkg::rsp_code_t code;
		logic [11:0]         gi;
		logic [23:0]         off;
		logic [12:0]         pc;
	} grant_t;

	typedef struct packed {
		row_kind_t          kind;
		fbfl_pkg::cfg_reg_t reg_sel;
		logic [12:0]        data;
		fbfl_pkg::func_t    f;
		logic [11:0]        idx;
		logic               pp;
		logic               typed;
		grant_t             want;
	} dir_row_t;

	typedef struct {
		logic [12:0] size;
		logic [12:0] page;
		int          count;
		int          pct;
	} traffic_mix_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [12:0] cfg_data;
	logic        req_valid;
	logic        req_stall;
	logic        func;
	logic [11:0] block_index;
	logic        pointer_present;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  status;
	logic [11:0] granted_index;
	logic [23:0] byte_offset;
	logic [12:0] page_count;

	// behavioral copy of the allocator state
	logic [11:0] link_mem [POOL_SIZE];
	bit          link_live [POOL_SIZE];
	bit          on_list [POOL_SIZE];
	logic [11:0] top_idx;
	bit          top_live;
	logic [12:0] pages_made;
	int unsigned blocks_carved;
	logic [12:0] cfg_size;
	logic [12:0] cfg_page;

	logic [11:0] granted_blocks [$];
	grant_t      pending_grants [$];
	bit          quiet_sender;
	int unsigned faults;
	int unsigned requests_sent;
	int unsigned cfg_writes;
	int unsigned status_tally [4];
	int unsigned idle_cycles;

	dir_row_t script [NROWS] = '{
		'{ROW_CFG, fbfl_pkg::CFG_PAGE_BLOCKS, 13'd16, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_ALLOC, 12'd15, 24'd240, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'hfff,
			1'b1, 1'b1, '{fbfl_pkg::RSP_ALLOC, 12'd14, 24'd224, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_IGNORED, 12'd0, 24'd0, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd4095,
			1'b1, 1'b1, '{fbfl_pkg::RSP_FREED, 12'd0, 24'd0, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_ALLOC, 12'd4095, 24'd65520, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd15,
			1'b1, 1'b1, '{fbfl_pkg::RSP_FREED, 12'd0, 24'd0, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd4095,
			1'b1, 1'b1, '{fbfl_pkg::RSP_FREED, 12'd0, 24'd0, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b1, 1'b1, '{fbfl_pkg::RSP_ALLOC, 12'd4095, 24'd65520, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_ALLOC, 12'd15, 24'd240, 13'd1}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd4095,
			1'b0, 1'b1, '{fbfl_pkg::RSP_IGNORED, 12'd0, 24'd0, 13'd1}},
		'{ROW_CFG, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd4095,
			1'b1, 1'b0, '0},
		'{ROW_CFG, fbfl_pkg::CFG_BLOCK_SIZE, 13'd8191, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_CFG, fbfl_pkg::CFG_BLOCK_SIZE, 13'd4096, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'haaa,
			1'b1, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'h555,
			1'b0, 1'b0, '0},
		'{ROW_DRAIN, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_CFG, fbfl_pkg::CFG_PAGE_BLOCKS, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_EXHAUSTED, 12'd0, 24'd0, 13'd1}},
		'{ROW_CFG, fbfl_pkg::CFG_PAGE_BLOCKS, 13'd8191, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b1, 1'b1, '{fbfl_pkg::RSP_EXHAUSTED, 12'd0, 24'd0, 13'd1}},
		'{ROW_CFG, fbfl_pkg::CFG_PAGE_BLOCKS, 13'd4096, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_EXHAUSTED, 12'd0, 24'd0, 13'd1}},
		'{ROW_CFG, fbfl_pkg::CFG_PAGE_BLOCKS, 13'd1, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b0, '0},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_ALLOC, 12'd0,
			1'b0, 1'b1, '{fbfl_pkg::RSP_ALLOC, 12'd16, 24'd65536, 13'd2}},
		'{ROW_ITEM, fbfl_pkg::CFG_BLOCK_SIZE, 13'd0, fbfl_pkg::FUNC_FREE, 12'd16,
			1'b1, 1'b1, '{fbfl_pkg::RSP_FREED, 12'd0, 24'd0, 13'd2}}
	};

	traffic_mix_t mixes [8] = '{
		'{13'd1, 13'd1, 150, 55},
		'{13'd4096, 13'd7, 120, 60},
		'{13'd8191, 13'd0, 100, 45},
		'{13'd0, 13'd100, 120, 60},
		'{13'd4095, 13'd8191, 80, 50},
		'{13'd8, 13'd4096, 80, 50},
		'{13'd13, 13'd3, 150, 55},
		'{13'd2000, 13'd1, 100, 50}
	};

	fixed_block_free_list_allocator #(
		.MAX_BLOCKS(POOL_SIZE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.block_index(block_index),
		.pointer_present(pointer_present),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.granted_index(granted_index),
		.byte_offset(byte_offset),
		.page_count(page_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned block_bytes();
		int unsigned s;
		s = (cfg_size < 13'd8) ? 8 : int'(cfg_size);
		return (s + 7) & ~32'd7;
	endfunction

	function automatic void push_free_block(int unsigned b);
		link_mem[b] = top_idx;
		link_live[b] = top_live;
		on_list[b] = 1'b1;
		top_idx = b[11:0];
		top_live = 1'b1;
	endfunction

	function automatic grant_t serve_request(fbfl_pkg::func_t f, logic [11:0] idx, logic pp);
		grant_t g;
		bit ok;
		int unsigned h;
		logic [63:0] prod;
		g = '0;
		ok = 1'b1;
		if (f == fbfl_pkg::FUNC_ALLOC) begin
			if (!top_live) begin
				if (cfg_page == 13'd0 || blocks_carved + cfg_page > POOL_SIZE) begin
					ok = 1'b0;
				end else begin
					for (int unsigned k = 0; k < cfg_page; k++)
						push_free_block(blocks_carved + k);
					blocks_carved += cfg_page;
					pages_made++;
				end
			end
			if (ok) begin
				h = top_idx;
				top_idx = link_mem[h];
				top_live = link_live[h];
				on_list[h] = 1'b0;
				prod = 64'(h) * 64'(block_bytes());
				g.code = fbfl_pkg::RSP_ALLOC;
				g.gi = h[11:0];
				g.off = prod[23:0];
			end else begin
				g.code = fbfl_pkg::RSP_EXHAUSTED;
			end
		end else if (!pp || idx >= POOL_SIZE) begin
			g.code = fbfl_pkg::RSP_IGNORED;
		end else begin
			push_free_block(idx);
			g.code = fbfl_pkg::RSP_FREED;
		end
		g.pc = pages_made;
		return g;
	endfunction

	function automatic int unsigned sender_gap();
		int unsigned r;
		if (quiet_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(fbfl_pkg::cfg_reg_t sel, logic [12:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (sel == fbfl_pkg::CFG_BLOCK_SIZE)
			cfg_size = d;
		else
			cfg_page = d;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(fbfl_pkg::func_t f, logic [11:0] idx, logic pp, bit typed,
		grant_t want);
		int unsigned gap;
		grant_t g;
		int hits [$];
		gap = sender_gap();
		if (gap != 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			func <= 1'($urandom);
			block_index <= 12'($urandom);
			pointer_present <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		func <= f;
		block_index <= idx;
		pointer_present <= pp;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		g = serve_request(f, idx, pp);
		if (g.code == fbfl_pkg::RSP_ALLOC) begin
			granted_blocks.insert(granted_blocks.size(), g.gi);
		end else if (g.code == fbfl_pkg::RSP_FREED) begin
			hits = granted_blocks.find_first_index(x) with (x == idx);
			if (hits.size() != 0)
				granted_blocks.delete(hits[0]);
		end
		pending_grants.insert(pending_grants.size(), typed ? want : g);
		requests_sent++;
	endtask

	task automatic drain_list();
		int unsigned n;
		n = 0;
		while (top_live && n < POOL_SIZE) begin
			send_item(fbfl_pkg::FUNC_ALLOC, 12'($urandom), 1'($urandom), 1'b0, '0);
			n++;
		end
	endtask

	task automatic run_traffic(int count, int pct);
		int unsigned r;
		logic [11:0] idx;
		for (int n = 0; n < count; n++) begin
			idx = 12'($urandom);
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < pct)
				send_item(fbfl_pkg::FUNC_ALLOC, idx, 1'($urandom), 1'b0, '0);
			else if (r < 70 && granted_blocks.size() != 0)
				send_item(fbfl_pkg::FUNC_FREE,
					granted_blocks[$urandom_range(0, granted_blocks.size() - 1)],
					1'b1, 1'b0, '0);
			else if (r < 85)
				// foreign free only of a block not already on the list
				send_item(fbfl_pkg::FUNC_FREE, idx, !on_list[idx], 1'b0, '0);
			else
				send_item(fbfl_pkg::FUNC_FREE, idx, 1'b0, 1'b0, '0);
		end
	endtask

	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 15))
				@(negedge clk) rsp_stall <= 1'b0;
			repeat (($urandom_range(0, 99) < 70) ? $urandom_range(1, 2) :
				(($urandom_range(0, 99) < 85) ? $urandom_range(3, 8) : $urandom_range(20, 60)))
				@(negedge clk) rsp_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_grants.size() == 0) begin
				report_fault($sformatf("unexpected response: status %0d index %0d offset %0d pages %0d",
					status, granted_index, byte_offset, page_count));
			end else begin
				want = pending_grants.pop_front();
				status_tally[want.code]++;
				if (status !== want.code || granted_index !== want.gi ||
					byte_offset !== want.off || page_count !== want.pc)
					report_fault($sformatf({"response mismatch: want %0d/%0d/%0d/%0d",
						" got %0d/%0d/%0d/%0d (status/index/offset/pages)"},
						want.code, want.gi, want.off, want.pc,
						status, granted_index, byte_offset, page_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		logic [11:0] victim;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = fbfl_pkg::CFG_BLOCK_SIZE;
		cfg_data = '0;
		req_valid = 1'b0;
		func = fbfl_pkg::FUNC_ALLOC;
		block_index = '0;
		pointer_present = 1'b0;
		link_mem = '{default: '0};
		link_live = '{default: 1'b0};
		on_list = '{default: 1'b0};
		top_idx = '0;
		top_live = 1'b0;
		pages_made = '0;
		blocks_carved = 0;
		cfg_size = 13'd16;
		cfg_page = 13'd1024;
		quiet_sender = 1'b0;
		faults = 0;
		requests_sent = 0;
		cfg_writes = 0;
		status_tally = '{default: 0};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_CFG: begin
					wait_idle();
					write_reg(script[i].reg_sel, script[i].data);
				end
				ROW_DRAIN: begin
					drain_list();
				end
				default: begin
					send_item(script[i].f, script[i].idx, script[i].pp, script[i].typed,
						script[i].want);
				end
			endcase
		end

		// each mix starts from an idle block, so the sender also waits out every response
		foreach (mixes[i]) begin
			wait_idle();
			write_reg(fbfl_pkg::CFG_BLOCK_SIZE, mixes[i].size);
			write_reg(fbfl_pkg::CFG_PAGE_BLOCKS, mixes[i].page);
			quiet_sender = ($urandom_range(0, 3) == 0);
			run_traffic(mixes[i].count, mixes[i].pct);
		end

		// last page fills the pool exactly
		quiet_sender = 1'b0;
		drain_list();
		wait_idle();
		write_reg(fbfl_pkg::CFG_PAGE_BLOCKS, 13'(POOL_SIZE - blocks_carved));
		write_reg(fbfl_pkg::CFG_BLOCK_SIZE, 13'd24);
		send_item(fbfl_pkg::FUNC_ALLOC, 12'($urandom), 1'($urandom), 1'b0, '0);
		run_traffic(40, 40);

		// double free corrupts the list into a self loop, so it comes last
		if (granted_blocks.size() != 0) begin
			victim = granted_blocks[0];
			send_item(fbfl_pkg::FUNC_FREE, victim, 1'b1, 1'b0, '0);
			send_item(fbfl_pkg::FUNC_FREE, victim, 1'b1, 1'b0, '0);
			repeat (4) send_item(fbfl_pkg::FUNC_ALLOC, 12'($urandom), 1'($urandom), 1'b0, '0);
		end
		@(negedge clk);
		req_valid <= 1'b0;

		wait_idle();
		repeat (20) @(posedge clk);
		$display("run: %0d requests (%0d grants, %0d frees, %0d null frees, %0d out of blocks)",
			requests_sent, status_tally[fbfl_pkg::RSP_ALLOC], status_tally[fbfl_pkg::RSP_FREED],
			status_tally[fbfl_pkg::RSP_IGNORED], status_tally[fbfl_pkg::RSP_EXHAUSTED]);
		$display("run: %0d register writes, %0d pages carved, %0d blocks carved, %0d mismatches",
			cfg_writes, pages_made, blocks_carved, faults);
		if (faults == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
